[design/assert_macros.svh]
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define NFCA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NFCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NFCA_ASSERT(lbl, clk, rst, prop, msg)
`define NFCA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/nfca_pkg.sv]
package nfca_pkg;

  localparam int RATIO_W  = 20;
  localparam int TICK_W   = 40;
  localparam int RELOAD_W = 12;
  localparam int PERIOD_W = 8;
  localparam int STEP_W   = 3;

  localparam logic [RATIO_W-1:0]  RATIO_RESET = 20'd309317;

  localparam logic [PERIOD_W-1:0] SUB_PERIODS = 8'd8;
  localparam logic [PERIOD_W-1:0] ONE_HOLD    = 8'd72;
  localparam logic [PERIOD_W-1:0] ZERO_LEAD   = 8'd64;

  localparam logic [STEP_W-1:0]   STEP_LEAD      = 3'd0;
  localparam logic [STEP_W-1:0]   STEP_FIRST_SUB = 3'd1;
  localparam logic [STEP_W-1:0]   STEP_FINAL     = 3'd7;

  localparam logic [RELOAD_W-1:0] RELOAD_MAX = 12'd4095;

  typedef struct packed {
    logic data_bit;
    logic frame_start;
    logic frame_end;
  } in_word_t;

  typedef struct packed {
    logic [RELOAD_W-1:0] reload_value;
    logic                level;
    logic                run_last;
  } out_word_t;

  typedef struct packed {
    logic                fire;
    logic                clear;
    logic [PERIOD_W-1:0] periods;
    logic                level;
    logic                last;
  } step_t;

endpackage

[design/nfca_subcarrier_edge_timer_encoder_unit.sv]
// A bit is registered in the sequencer; each step passes the pend and out registers.
// Throughput: 7 or 8 interval words per input bit, one per cycle while nothing stalls,
//   set by the step sequencer; the next bit is taken in the cycle its predecessor
//   issues its final step. A ratio write stalls input while the shift-add rebuilds
//   the carrier-time product. Reset (rst, synchronous) empties the pipe, clears totals.
module nfca_subcarrier_edge_timer_encoder_unit #(
  parameter int RATIO_FRAC_BITS    = 16,
  parameter int CARRIER_TOTAL_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  nfca_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output nfca_pkg::out_word_t          out_data,
  input  logic                         cfg_we,
  input  logic [nfca_pkg::RATIO_W-1:0] cfg_data
);

  localparam int ACC_W = nfca_pkg::TICK_W + RATIO_FRAC_BITS;

  nfca_pkg::step_t  step;
  logic             go;
  logic             busy;
  logic [ACC_W-1:0] acc;

  nfca_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .go       (go),
    .busy     (busy),
    .step     (step)
  );

  nfca_acc #(
    .RATIO_FRAC_BITS    (RATIO_FRAC_BITS),
    .CARRIER_TOTAL_BITS (CARRIER_TOTAL_BITS)
  ) u_acc (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (step),
    .busy     (busy),
    .acc      (acc)
  );

  nfca_tick #(
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_tick (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .acc       (acc),
    .go        (go),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[design/nfca_seq.sv]
`include "assert_macros.svh"

module nfca_seq (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  nfca_pkg::in_word_t in_data,
  input  logic               go,
  input  logic               busy,
  output nfca_pkg::step_t    step
);

  logic                        item_valid;
  nfca_pkg::in_word_t          item;
  logic                        fresh;
  logic [nfca_pkg::STEP_W-1:0] step_q;
  logic                        held_valid;
  logic                        held_one;

  logic                          hv_e;
  logic [nfca_pkg::STEP_W-1:0]   cur_step;
  logic                          fire;
  logic                          done;
  logic                          load;
  logic [nfca_pkg::PERIOD_W-1:0] held_len;

  always_comb begin
    hv_e     = held_valid && !item.frame_start;
    cur_step = fresh ? ((item.data_bit && !hv_e) ? nfca_pkg::STEP_FIRST_SUB
                                                 : nfca_pkg::STEP_LEAD)
                     : step_q;
    fire     = item_valid && go && !busy;
    done     = fire && (cur_step == nfca_pkg::STEP_FINAL);
    held_len = held_one ? nfca_pkg::ONE_HOLD : nfca_pkg::SUB_PERIODS;

    step.fire  = fire;
    step.clear = fresh && item.frame_start;
    step.last  = (cur_step == nfca_pkg::STEP_FINAL);
    if (cur_step == nfca_pkg::STEP_LEAD) begin
      step.level   = 1'b0;
      step.periods = item.data_bit ? held_len
                                   : nfca_pkg::ZERO_LEAD + (hv_e ? held_len : '0);
    end else begin
      step.level   = cur_step[0];
      step.periods = nfca_pkg::SUB_PERIODS;
    end

    in_stall = busy || (item_valid && !done);
    load     = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      fresh      <= 1'b0;
      step_q     <= '0;
      held_valid <= 1'b0;
      held_one   <= 1'b0;
    end else begin
      if (done) begin
        held_valid <= !item.frame_end;
        held_one   <= item.data_bit;
      end
      if (fire) begin
        step_q <= cur_step + 1'b1;
      end
      if (load) begin
        item_valid <= 1'b1;
        fresh      <= 1'b1;
      end else if (done) begin
        item_valid <= 1'b0;
        fresh      <= 1'b0;
      end else if (fire) begin
        fresh <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_data;
    end
  end

  `NFCA_ASSERT(a_next_fresh, clk, rst, done |=> (!item_valid || fresh), "word left stale")
  `NFCA_ASSERT(a_no_fire_busy, clk, rst, busy |-> !fire, "step fired during product rebuild")

endmodule

[design/nfca_acc.sv]
`include "assert_macros.svh"

module nfca_acc #(
  parameter int RATIO_FRAC_BITS    = 16,
  parameter int CARRIER_TOTAL_BITS = 32,
  localparam int ACC_W = nfca_pkg::TICK_W + RATIO_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [nfca_pkg::RATIO_W-1:0] cfg_data,
  input  nfca_pkg::step_t              step,
  output logic                         busy,
  output logic [ACC_W-1:0]             acc
);

  localparam int C      = CARRIER_TOTAL_BITS;
  localparam int IW     = $clog2(C);
  localparam int PROD_W = nfca_pkg::PERIOD_W + nfca_pkg::RATIO_W;
  localparam int WIDE_W = nfca_pkg::RATIO_W + C + ACC_W;

  logic [nfca_pkg::RATIO_W-1:0] ratio;
  logic [C-1:0]                 carrier;
  logic [IW-1:0]                idx;

  logic [C-1:0]      c_base;
  logic [ACC_W-1:0]  acc_base;
  logic [C:0]        c_sum;
  logic [PROD_W-1:0] prod;
  logic [WIDE_W-1:0] wrap_full;
  logic [ACC_W-1:0]  wrap_term;
  logic [ACC_W-1:0]  acc_step;
  logic [ACC_W-1:0]  acc_shift;

  always_comb begin
    c_base    = step.clear ? '0 : carrier;
    acc_base  = step.clear ? '0 : acc;
    c_sum     = {1'b0, c_base} + (C+1)'(step.periods);
    prod      = step.periods * ratio;
    wrap_full = {{ACC_W{1'b0}}, ratio, {C{1'b0}}};
    wrap_term = wrap_full[ACC_W-1:0];
    acc_step  = acc_base + ACC_W'(prod) - (c_sum[C] ? wrap_term : '0);
    acc_shift = {acc[ACC_W-2:0], 1'b0} + (carrier[idx] ? ACC_W'(ratio) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ratio   <= nfca_pkg::RATIO_RESET;
      carrier <= '0;
      acc     <= '0;
      busy    <= 1'b0;
      idx     <= '0;
    end else if (cfg_we) begin
      ratio <= cfg_data;
      busy  <= 1'b1;
      acc   <= '0;
      idx   <= IW'(C - 1);
    end else if (busy) begin
      acc <= acc_shift;
      idx <= idx - 1'b1;
      if (idx == '0) begin
        busy <= 1'b0;
      end
    end else if (step.fire) begin
      carrier <= c_sum[C-1:0];
      acc     <= acc_step;
    end
  end

  `NFCA_ASSERT(a_rebuild_len, clk, rst, (busy && idx == '0 && !cfg_we) |=> !busy, "rebuild did not end")

endmodule

[design/nfca_tick.sv]
`include "assert_macros.svh"

module nfca_tick #(
  parameter int RATIO_FRAC_BITS = 16,
  localparam int ACC_W = nfca_pkg::TICK_W + RATIO_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  nfca_pkg::step_t     step,
  input  logic [ACC_W-1:0]    acc,
  output logic                go,
  output logic                out_valid,
  input  logic                out_stall,
  output nfca_pkg::out_word_t out_data
);

  localparam int TW = nfca_pkg::TICK_W;
  localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (RATIO_FRAC_BITS - 1);

  logic          pend_valid;
  logic          pend_level;
  logic          pend_last;
  logic          pend_clear;
  logic [TW-1:0] tick;

  logic                          take;
  logic [ACC_W-1:0]              acc_round;
  logic [TW-1:0]                 target;
  logic [TW-1:0]                 diff;
  logic [TW-1:0]                 diff_m1;
  logic [nfca_pkg::RELOAD_W-1:0] reload;

  always_comb begin
    take      = !out_valid || !out_stall;
    go        = !pend_valid || take;
    acc_round = acc + HALF;
    target    = acc_round[ACC_W-1:RATIO_FRAC_BITS];
    diff      = target - (pend_clear ? '0 : tick);
    diff_m1   = diff - 1'b1;
    if (diff == '0) begin
      reload = '0;
    end else if (diff_m1 > TW'(nfca_pkg::RELOAD_MAX)) begin
      reload = nfca_pkg::RELOAD_MAX;
    end else begin
      reload = diff_m1[nfca_pkg::RELOAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      tick       <= '0;
    end else begin
      if (go) begin
        pend_valid <= step.fire;
      end
      if (take) begin
        out_valid <= pend_valid;
      end
      if (take && pend_valid) begin
        tick <= target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && step.fire) begin
      pend_level <= step.level;
      pend_last  <= step.last;
      pend_clear <= step.clear;
    end
    if (take && pend_valid) begin
      out_data.reload_value <= reload;
      out_data.level        <= pend_level;
      out_data.run_last     <= pend_last;
    end
  end

  `NFCA_ASSERT(a_fire_has_room, clk, rst, step.fire |-> go, "step fired into a full stage")
  `NFCA_ASSERT(a_pend_kept, clk, rst, (pend_valid && !take) |=> pend_valid, "pending word lost")

endmodule

[sim/nfca_encoder_checker.sv]
`timescale 1ns / 1ps
module nfca_encoder_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  nfca_pkg::in_word_t           in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  nfca_pkg::out_word_t          out_data,
  input  logic                         cfg_we,
  input  logic [nfca_pkg::RATIO_W-1:0] cfg_data,
  output int                           pending,
  output int                           errors
);

  localparam int CARRIER_W  = 32;
  localparam int RATIO_FRAC = 16;

  logic [nfca_pkg::RATIO_W-1:0]  ratio = nfca_pkg::RATIO_RESET;
  logic [nfca_pkg::PERIOD_W-1:0] held_len = '0;
  logic                          held_ok = 1'b0;
  logic [CARRIER_W-1:0]          carrier_sum = '0;
  logic [nfca_pkg::TICK_W-1:0]   tick_pos = '0;
  nfca_pkg::out_word_t           interval_q[$];
  int                            waiting = 0;
  int                            err_cnt = 0;

  assign pending = waiting;
  assign errors  = err_cnt;

  task automatic push_interval(input logic [nfca_pkg::PERIOD_W-1:0] periods, input logic lvl);
    logic [63:0]                 prod;
    logic [nfca_pkg::TICK_W-1:0] target;
    logic [nfca_pkg::TICK_W-1:0] diff;
    nfca_pkg::out_word_t         w;
    carrier_sum = carrier_sum + CARRIER_W'(periods);
    prod = 64'(carrier_sum) * 64'(ratio) + (64'd1 << (RATIO_FRAC - 1));
    target = nfca_pkg::TICK_W'(prod >> RATIO_FRAC);
    diff = target - tick_pos;
    if (diff == '0) begin
      w.reload_value = '0;
    end else if (diff - 1 > nfca_pkg::TICK_W'(nfca_pkg::RELOAD_MAX)) begin
      w.reload_value = nfca_pkg::RELOAD_MAX;
    end else begin
      w.reload_value = nfca_pkg::RELOAD_W'(diff - 1);
    end
    w.level = lvl;
    w.run_last = 1'b0;
    tick_pos = target;
    interval_q.push_back(w);
  endtask

  task automatic encode_bit(input nfca_pkg::in_word_t w);
    logic [nfca_pkg::PERIOD_W-1:0] lead;
    nfca_pkg::out_word_t           tail;
    if (w.frame_start) begin
      held_len = '0;
      held_ok = 1'b0;
      carrier_sum = '0;
      tick_pos = '0;
    end
    if (w.data_bit) begin
      if (held_ok) push_interval(held_len, 1'b0);
      for (int i = 0; i < 7; i++) push_interval(nfca_pkg::SUB_PERIODS, (i % 2) == 0);
      held_len = nfca_pkg::ONE_HOLD;
    end else begin
      lead = nfca_pkg::ZERO_LEAD + (held_ok ? held_len : '0);
      push_interval(lead, 1'b0);
      for (int i = 0; i < 7; i++) push_interval(nfca_pkg::SUB_PERIODS, (i % 2) == 0);
      held_len = nfca_pkg::SUB_PERIODS;
    end
    held_ok = 1'b1;
    if (w.frame_end) begin
      held_len = '0;
      held_ok = 1'b0;
    end
    tail = interval_q.pop_back();
    tail.run_last = 1'b1;
    interval_q.push_back(tail);
  endtask

  always @(posedge clk) begin
    nfca_pkg::out_word_t want;
    if (rst) begin
      ratio = nfca_pkg::RATIO_RESET;
      held_len = '0;
      held_ok = 1'b0;
      carrier_sum = '0;
      tick_pos = '0;
      interval_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (interval_q.size() == 0) begin
          $error("unexpected interval word %p", out_data);
          err_cnt++;
        end else begin
          want = interval_q.pop_front();
          if (out_data.reload_value !== want.reload_value) begin
            $error("reload_value: expected %0d, got %0d", want.reload_value,
                   out_data.reload_value);
            err_cnt++;
          end
          if (out_data.level !== want.level) begin
            $error("level: expected %0d, got %0d", want.level, out_data.level);
            err_cnt++;
          end
          if (out_data.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_data.run_last);
            err_cnt++;
          end
        end
      end
      if (cfg_we) ratio = cfg_data;
      if (in_valid && !in_stall) encode_bit(in_data);
    end
    waiting <= interval_q.size();
  end

endmodule

[sim/tb_nfca_subcarrier_edge_timer_encoder_unit.sv]
`timescale 1ns / 1ps
module tb_nfca_subcarrier_edge_timer_encoder_unit;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  nfca_pkg::in_word_t           in_data = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  nfca_pkg::out_word_t          out_data;
  logic                         cfg_we = 1'b0;
  logic [nfca_pkg::RATIO_W-1:0] cfg_data = nfca_pkg::RATIO_RESET;
  int                           pending;
  int                           errors;
  int                           bits_sent = 0;
  int                           holds_asked = 0;
  int                           holds_done = 0;

  nfca_subcarrier_edge_timer_encoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  nfca_encoder_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .errors    (errors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  initial begin
    bit stall_now;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else if ($urandom_range(0, 9) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        stall_now = ($urandom_range(0, 2) == 0);
        out_stall <= stall_now;
        repeat (stall_now ? 1 + gap_len() : $urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  task automatic send_bit(input logic d, input logic s, input logic e, input bit no_gaps);
    int g;
    g = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{data_bit: d, frame_start: s, frame_end: e};
    do @(posedge clk); while (in_stall);
    bits_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ratio(input logic [nfca_pkg::RATIO_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame(input bit no_gaps);
    int  len;
    int  kind;
    bit  s;
    bit  e;
    len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 19);
    kind = $urandom_range(0, 9);
    for (int k = 0; k < len; k++) begin
      if (kind == 3) begin
        s = ($urandom_range(0, 3) == 0);
        e = ($urandom_range(0, 3) == 0);
      end else begin
        s = (k == 0) && kind != 0 && kind != 2;
        e = (k == len - 1) && kind != 1 && kind != 2;
      end
      send_bit(1'($urandom_range(0, 1)), s, e, no_gaps);
    end
  endtask

  initial begin
    logic [nfca_pkg::RATIO_W-1:0] r;
    int                           mark;
    bit                           burst;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_bit(1'b1, 1'b1, 1'b1, 1'b0);
    send_bit(1'b0, 1'b1, 1'b1, 1'b0);
    send_bit(1'b1, 1'b1, 1'b0, 1'b0);
    send_bit(1'b0, 1'b0, 1'b0, 1'b0);
    send_bit(1'b0, 1'b0, 1'b0, 1'b0);
    send_bit(1'b1, 1'b0, 1'b0, 1'b0);
    send_bit(1'b1, 1'b0, 1'b0, 1'b0);
    send_bit(1'b0, 1'b0, 1'b0, 1'b0);
    send_bit(1'b1, 1'b0, 1'b1, 1'b0);
    send_bit(1'b0, 1'b0, 1'b0, 1'b0);
    send_bit(1'b1, 1'b0, 1'b1, 1'b0);
    send_bit(1'b1, 1'b1, 1'b0, 1'b0);
    send_bit(1'b0, 1'b0, 1'b0, 1'b0);
    // raise the ratio mid-frame, then drop it: tick target jumps ahead, then behind
    write_ratio(20'hFFFFF);
    send_bit(1'b1, 1'b0, 1'b0, 1'b0);
    write_ratio(20'd65536);
    send_bit(1'b0, 1'b0, 1'b1, 1'b0);
    write_ratio(20'd0);
    send_bit(1'b1, 1'b1, 1'b0, 1'b0);
    send_bit(1'b0, 1'b0, 1'b1, 1'b0);
    write_ratio(20'd1);
    send_bit(1'b0, 1'b1, 1'b0, 1'b0);
    send_bit(1'b1, 1'b0, 1'b1, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: r = nfca_pkg::RATIO_RESET;
        1: r = 20'd65536;
        2: r = 20'hFFFFF;
        default: r = nfca_pkg::RATIO_W'($urandom_range(65536, 1048575));
      endcase
      write_ratio(r);
      burst = (phase == 2) || ($urandom_range(0, 3) == 0);
      if (phase == 2) holds_asked++;
      mark = bits_sent;
      while (bits_sent - mark < 26) random_frame(burst);
    end

    drain();
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/nfca_pkg.sv
design/nfca_seq.sv
design/nfca_acc.sv
design/nfca_tick.sv
design/nfca_subcarrier_edge_timer_encoder_unit.sv
sim/nfca_encoder_checker.sv
sim/tb_nfca_subcarrier_edge_timer_encoder_unit.sv
